@@ rtl/hdc_pkg.sv @@
package hdc_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int LEN_W       = 7;
  localparam int IN_W        = 16;
  localparam int OUT_W       = 40;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [LEN_W-1:0] LEN_RST = 7'd64;

  // register index, taken from paddr word bit
  localparam logic REG_LENGTH = 1'b0;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RUN,
    ST_DRAIN
  } hdc_state_t;

  // which partial sum a term belongs to
  typedef enum logic [1:0] {
    TM_CAUSAL,
    TM_CONJ_G,
    TM_CONJ_F
  } term_mode_t;

  typedef struct packed {
    logic       valid;
    term_mode_t mode;
    logic       first;
    logic       emit;
    logic       last;
  } hdc_tag_t;

  typedef struct packed {
    logic     load;
    hdc_tag_t tag;
  } hdc_cmd_t;

  typedef struct packed {
    logic batch_done;
  } hdc_sts_t;

endpackage

@@ rtl/hdc_ctrl.sv @@
module hdc_ctrl #(
  parameter int MAX_LEN = hdc_pkg::MAX_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       cfg_clr,
  input  logic [$clog2(MAX_LEN)-1:0] m1,
  input  hdc_pkg::hdc_sts_t          sts,
  output logic                       busy,
  output hdc_pkg::hdc_cmd_t          cmd,
  output logic [$clog2(MAX_LEN)-1:0] wr_addr,
  output logic [$clog2(MAX_LEN)-1:0] f_addr,
  output logic [$clog2(MAX_LEN)-1:0] g_addr
);

  localparam int IW = $clog2(MAX_LEN);

  hdc_pkg::hdc_state_t state_r, state_nxt;
  hdc_pkg::term_mode_t ph_r, ph_nxt;
  logic [IW-1:0]       i_r, i_nxt;
  logic [IW-1:0]       j_r, j_nxt;
  logic [IW-1:0]       lc_r, lc_nxt;
  logic [IW-1:0]       lc_base;
  logic                out_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hdc_pkg::ST_LOAD;
      ph_r    <= hdc_pkg::TM_CAUSAL;
      i_r     <= '0;
      j_r     <= '0;
      lc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      lc_r    <= lc_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    lc_nxt    = lc_r;
    cmd       = '0;
    out_end   = 1'b0;
    busy      = (state_r != hdc_pkg::ST_LOAD);
    wr_addr   = lc_r;
    f_addr    = j_r;
    lc_base   = cfg_clr ? '0 : lc_r;

    case (ph_r)
      hdc_pkg::TM_CONJ_G: g_addr = j_r - i_r;
      hdc_pkg::TM_CONJ_F: g_addr = i_r + j_r;
      default:            g_addr = i_r - j_r;
    endcase

    case (state_r)
      hdc_pkg::ST_LOAD: begin
        lc_nxt  = lc_base;
        wr_addr = lc_base;
        if (start) begin
          cmd.load = 1'b1;
          if (lc_base == m1) begin
            lc_nxt    = '0;
            i_nxt     = '0;
            j_nxt     = '0;
            ph_nxt    = hdc_pkg::TM_CAUSAL;
            state_nxt = hdc_pkg::ST_RUN;
          end else begin
            lc_nxt = lc_base + IW'(1);
          end
        end
      end

      hdc_pkg::ST_RUN: begin
        cmd.tag.valid = 1'b1;
        cmd.tag.mode  = ph_r;
        cmd.tag.first = (ph_r == hdc_pkg::TM_CAUSAL) && (j_r == '0);
        case (ph_r)
          hdc_pkg::TM_CAUSAL: begin
            if (j_r == i_r) begin
              if (i_r == m1) begin
                out_end = 1'b1;
              end else begin
                ph_nxt = hdc_pkg::TM_CONJ_G;
                j_nxt  = i_r + IW'(1);
              end
            end else begin
              j_nxt = j_r + IW'(1);
            end
          end
          hdc_pkg::TM_CONJ_G: begin
            if (j_r == m1) begin
              ph_nxt = hdc_pkg::TM_CONJ_F;
              j_nxt  = IW'(1);
            end else begin
              j_nxt = j_r + IW'(1);
            end
          end
          hdc_pkg::TM_CONJ_F: begin
            if (j_r == m1 - i_r) begin
              out_end = 1'b1;
            end else begin
              j_nxt = j_r + IW'(1);
            end
          end
          default: begin
            out_end = 1'b1;
          end
        endcase
        if (out_end) begin
          cmd.tag.emit = 1'b1;
          ph_nxt       = hdc_pkg::TM_CAUSAL;
          j_nxt        = '0;
          if (i_r == m1) begin
            cmd.tag.last = 1'b1;
            state_nxt    = hdc_pkg::ST_DRAIN;
          end else begin
            i_nxt = i_r + IW'(1);
          end
        end
      end

      hdc_pkg::ST_DRAIN: begin
        if (sts.batch_done) begin
          state_nxt = hdc_pkg::ST_LOAD;
        end
      end

      default: begin
        state_nxt = hdc_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

@@ rtl/hdc_dp.sv @@
module hdc_dp #(
  parameter int MAX_LEN = hdc_pkg::MAX_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hdc_pkg::hdc_cmd_t                   cmd,
  input  logic [$clog2(MAX_LEN)-1:0]          wr_addr,
  input  logic [$clog2(MAX_LEN)-1:0]          f_addr,
  input  logic [$clog2(MAX_LEN)-1:0]          g_addr,
  input  logic signed [hdc_pkg::IN_W-1:0]     f_re,
  input  logic signed [hdc_pkg::IN_W-1:0]     f_im,
  input  logic signed [hdc_pkg::IN_W-1:0]     g_re,
  input  logic signed [hdc_pkg::IN_W-1:0]     g_im,
  output hdc_pkg::hdc_sts_t                   sts,
  output logic                                h_valid,
  output logic signed [hdc_pkg::OUT_W-1:0]    h_re,
  output logic signed [hdc_pkg::OUT_W-1:0]    h_im,
  output logic                                h_last
);

  localparam int IN_W  = hdc_pkg::IN_W;
  localparam int OUT_W = hdc_pkg::OUT_W;
  localparam int PW    = 2 * IN_W;
  localparam int TW    = PW + 1;
  // up to 2*MAX_LEN-1 terms of at most 2^31 each
  localparam int ACC_W = PW + 2 + $clog2(MAX_LEN);
  localparam int SW    = (ACC_W > OUT_W) ? ACC_W : OUT_W;

  logic [PW-1:0] f_mem [MAX_LEN];
  logic [PW-1:0] g_mem [MAX_LEN];

  logic [PW-1:0] f_rd_r, g_rd_r;
  hdc_pkg::hdc_tag_t tag1_r, tag2_r, tag3_r, tag4_r;

  logic signed [IN_W-1:0] fr, fi, gr, gi;
  logic signed [PW-1:0]   pa_r, pb_r, pc_r, pd_r;
  logic signed [TW-1:0]   t_re, t_im, t_re_r, t_im_r;
  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;
  logic signed [SW-1:0]   ext_re, ext_im;
  logic                   h_valid_r, h_last_r;
  logic signed [OUT_W-1:0] h_re_r, h_im_r;

  // operand stores, re in the low half
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      f_mem[wr_addr] <= {f_im, f_re};
      g_mem[wr_addr] <= {g_im, g_re};
    end
    f_rd_r <= f_mem[f_addr];
    g_rd_r <= g_mem[g_addr];
  end

  assign fr = f_rd_r[IN_W-1:0];
  assign fi = f_rd_r[PW-1:IN_W];
  assign gr = g_rd_r[IN_W-1:0];
  assign gi = g_rd_r[PW-1:IN_W];

  always_ff @(posedge clk) begin
    pa_r <= fr * gr;
    pb_r <= fi * gi;
    pc_r <= fr * gi;
    pd_r <= fi * gr;
  end

  always_comb begin
    case (tag2_r.mode)
      hdc_pkg::TM_CONJ_G: begin
        t_re = TW'(pa_r) + TW'(pb_r);
        t_im = TW'(pd_r) - TW'(pc_r);
      end
      hdc_pkg::TM_CONJ_F: begin
        t_re = TW'(pa_r) + TW'(pb_r);
        t_im = TW'(pc_r) - TW'(pd_r);
      end
      default: begin
        t_re = TW'(pa_r) - TW'(pb_r);
        t_im = TW'(pc_r) + TW'(pd_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    t_re_r <= t_re;
    t_im_r <= t_im;
    if (tag3_r.valid) begin
      acc_re_r <= (tag3_r.first ? '0 : acc_re_r) + ACC_W'(t_re_r);
      acc_im_r <= (tag3_r.first ? '0 : acc_im_r) + ACC_W'(t_im_r);
    end
  end

  assign ext_re = SW'(acc_re_r);
  assign ext_im = SW'(acc_im_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r    <= '0;
      tag2_r    <= '0;
      tag3_r    <= '0;
      tag4_r    <= '0;
      h_valid_r <= 1'b0;
    end else begin
      tag1_r    <= cmd.tag;
      tag2_r    <= tag1_r;
      tag3_r    <= tag2_r;
      tag4_r    <= tag3_r;
      h_valid_r <= tag4_r.valid && tag4_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    h_last_r <= tag4_r.last;
    if (ext_re > SW'(hdc_pkg::OUT_MAX)) begin
      h_re_r <= hdc_pkg::OUT_MAX;
    end else if (ext_re < SW'(hdc_pkg::OUT_MIN)) begin
      h_re_r <= hdc_pkg::OUT_MIN;
    end else begin
      h_re_r <= ext_re[OUT_W-1:0];
    end
    if (ext_im > SW'(hdc_pkg::OUT_MAX)) begin
      h_im_r <= hdc_pkg::OUT_MAX;
    end else if (ext_im < SW'(hdc_pkg::OUT_MIN)) begin
      h_im_r <= hdc_pkg::OUT_MIN;
    end else begin
      h_im_r <= ext_im[OUT_W-1:0];
    end
  end

  assign h_valid        = h_valid_r;
  assign h_re           = h_re_r;
  assign h_im           = h_im_r;
  assign h_last         = h_last_r;
  assign sts.batch_done = h_valid_r && h_last_r;

endmodule

@@ rtl/hermitian_direct_convolution_top.sv @@
// Channel   Direction  Handshake               Payload
// input     in         start & !busy           in_f_re, in_f_im, in_g_re, in_g_im
// result    out        out_valid (one cycle)   out_h_re, out_h_im, out_last
// config    in/out     APB, psel&penable&pwrite  length at 0x0, pready tied high
//
// A batch of m = length items loads at one item a cycle; the item that
// completes it raises busy. The single complex MAC then runs m*(3m-1)/2
// terms, one per cycle, fed by one read port on each operand store;
// results pass through the read, product, term, accumulator and output
// registers behind the term stream, and no new batch loads until it ends.
// Synchronous active-low reset clears control only; the stores hold
// whatever was last written. The receiver cannot stall: each result is
// shown for exactly one cycle and busy drops the cycle after the last one.
module hermitian_direct_convolution_top #(
  parameter int MAX_LEN = hdc_pkg::MAX_LEN_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [hdc_pkg::IN_W-1:0]      in_f_re,
  input  logic signed [hdc_pkg::IN_W-1:0]      in_f_im,
  input  logic signed [hdc_pkg::IN_W-1:0]      in_g_re,
  input  logic signed [hdc_pkg::IN_W-1:0]      in_g_im,
  // result channel
  output logic                                 out_valid,
  output logic signed [hdc_pkg::OUT_W-1:0]     out_h_re,
  output logic signed [hdc_pkg::OUT_W-1:0]     out_h_im,
  output logic                                 out_last,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [hdc_pkg::PADDR_W-1:0]          paddr,
  input  logic [hdc_pkg::PDATA_W-1:0]          pwdata,
  output logic [hdc_pkg::PDATA_W-1:0]          prdata,
  output logic                                 pready
);

  localparam int IW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  logic [hdc_pkg::LEN_W-1:0] len_r, len_nxt;
  logic                      cfg_wr;
  logic [CW-1:0]             eff_len;
  logic [IW-1:0]             m1;

  hdc_pkg::hdc_cmd_t cmd;
  hdc_pkg::hdc_sts_t sts;
  logic [IW-1:0]     wr_addr, f_addr, g_addr;

  // register transfer: word bit selects the register, byte bits ignored
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[hdc_pkg::PADDR_W-1] == hdc_pkg::REG_LENGTH);

  always_comb begin
    len_nxt = len_r;
    if (cfg_wr) begin
      len_nxt = pwdata[hdc_pkg::LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= hdc_pkg::LEN_RST;
    end else begin
      len_r <= len_nxt;
    end
  end

  assign prdata = (paddr[hdc_pkg::PADDR_W-1] == hdc_pkg::REG_LENGTH) ?
                  hdc_pkg::PDATA_W'(len_r) : '0;

  // zero acts as one, anything above the store depth clamps to it
  always_comb begin
    if (len_r == '0) begin
      eff_len = CW'(1);
    end else if (int'(len_r) > MAX_LEN) begin
      eff_len = CW'(MAX_LEN);
    end else begin
      eff_len = CW'(len_r);
    end
  end

  assign m1 = IW'(eff_len - CW'(1));

  hdc_ctrl #(
    .MAX_LEN (MAX_LEN)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .cfg_clr (cfg_wr),
    .m1      (m1),
    .sts     (sts),
    .busy    (busy),
    .cmd     (cmd),
    .wr_addr (wr_addr),
    .f_addr  (f_addr),
    .g_addr  (g_addr)
  );

  hdc_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .wr_addr (wr_addr),
    .f_addr  (f_addr),
    .g_addr  (g_addr),
    .f_re    (in_f_re),
    .f_im    (in_f_im),
    .g_re    (in_g_re),
    .g_im    (in_g_im),
    .sts     (sts),
    .h_valid (out_valid),
    .h_re    (out_h_re),
    .h_im    (out_h_im),
    .h_last  (out_last)
  );

endmodule

@@ rtl/hdc_chk.sv @@
module hdc_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_last
);

  // results only while a batch is being worked
  a_out_in_batch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result outside a batch");

  // last only rides on a strobe
  a_last_strobed: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid)
    else $error("last without strobe");

  // busy only rises on an accepted item
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) && $past(rst_n) |-> $past(start))
    else $error("busy rose without start");

  // busy only falls after the final result of the batch
  a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> $past(out_valid && out_last))
    else $error("batch closed before final result");

endmodule

bind hermitian_direct_convolution_top hdc_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_last  (out_last)
);

@@ tb/sv/hdc_spectrum_checker.sv @@
`timescale 1ns / 1ps

// Watches the input, result and register channels, predicts the H components
// of each completed batch and compares them in order.
module hdc_spectrum_checker #(
  parameter int MAX_LEN = hdc_pkg::MAX_LEN_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               busy,
  input  logic signed [hdc_pkg::IN_W-1:0]    in_f_re,
  input  logic signed [hdc_pkg::IN_W-1:0]    in_f_im,
  input  logic signed [hdc_pkg::IN_W-1:0]    in_g_re,
  input  logic signed [hdc_pkg::IN_W-1:0]    in_g_im,
  input  logic                               out_valid,
  input  logic signed [hdc_pkg::OUT_W-1:0]   out_h_re,
  input  logic signed [hdc_pkg::OUT_W-1:0]   out_h_im,
  input  logic                               out_last,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic                               pready,
  input  logic [hdc_pkg::PADDR_W-1:0]        paddr,
  input  logic [hdc_pkg::PDATA_W-1:0]        pwdata,
  output int                                 n_fail,
  output int                                 n_pending,
  output int                                 n_checked
);
  import hdc_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] re;
    logic signed [OUT_W-1:0] im;
    logic                    last;
  } h_comp_t;

  h_comp_t                h_pending_q[$];
  logic signed [IN_W-1:0] f_re_mem [MAX_LEN];
  logic signed [IN_W-1:0] f_im_mem [MAX_LEN];
  logic signed [IN_W-1:0] g_re_mem [MAX_LEN];
  logic signed [IN_W-1:0] g_im_mem [MAX_LEN];
  logic [LEN_W-1:0]       length_reg;
  int                     loaded;
  int                     m_eff;

  function automatic logic signed [OUT_W-1:0] clamp_h(longint v);
    if (v > longint'(OUT_MAX)) return OUT_MAX;
    if (v < longint'(OUT_MIN)) return OUT_MIN;
    return v[OUT_W-1:0];
  endfunction

  // zero acts as one, anything past the store depth saturates
  function automatic int batch_len(logic [LEN_W-1:0] l);
    if (l == '0) return 1;
    if (int'(l) > MAX_LEN) return MAX_LEN;
    return int'(l);
  endfunction

  // causal sum plus the two sums wrapped through conj(G) and conj(F)
  function automatic void convolve_batch(int m);
    longint  sr, si, fr, fi, gr, gi;
    h_comp_t c;
    for (int i = 0; i < m; i++) begin
      sr = 0;
      si = 0;
      for (int j = 0; j <= i; j++) begin
        fr = longint'(f_re_mem[j]);   fi = longint'(f_im_mem[j]);
        gr = longint'(g_re_mem[i-j]); gi = longint'(g_im_mem[i-j]);
        sr += fr * gr - fi * gi;
        si += fr * gi + fi * gr;
      end
      for (int j = i + 1; j < m; j++) begin
        fr = longint'(f_re_mem[j]);   fi = longint'(f_im_mem[j]);
        gr = longint'(g_re_mem[j-i]); gi = longint'(g_im_mem[j-i]);
        sr += fr * gr + fi * gi;
        si += fi * gr - fr * gi;
      end
      for (int j = 1; j < m - i; j++) begin
        fr = longint'(f_re_mem[j]);   fi = longint'(f_im_mem[j]);
        gr = longint'(g_re_mem[i+j]); gi = longint'(g_im_mem[i+j]);
        sr += fr * gr + fi * gi;
        si += fr * gi - fi * gr;
      end
      c.re   = clamp_h(sr);
      c.im   = clamp_h(si);
      c.last = (i + 1 == m);
      h_pending_q.push_back(c);
    end
  endfunction

  always @(posedge clk) begin
    h_comp_t exp_c;
    if (!rst_n) begin
      h_pending_q.delete();
      loaded     = 0;
      length_reg = LEN_RST;
      n_pending <= 0;
    end else begin
      if (out_valid) begin
        if (h_pending_q.size() == 0) begin
          $error("unexpected result: h_re %0d h_im %0d last %0b", out_h_re, out_h_im, out_last);
          n_fail++;
        end else begin
          exp_c = h_pending_q.pop_front();
          n_checked++;
          if (out_h_re !== exp_c.re) begin
            $error("h_re mismatch: expected %0d, got %0d", exp_c.re, out_h_re);
            n_fail++;
          end
          if (out_h_im !== exp_c.im) begin
            $error("h_im mismatch: expected %0d, got %0d", exp_c.im, out_h_im);
            n_fail++;
          end
          if (out_last !== exp_c.last) begin
            $error("last mismatch: expected %0b, got %0b", exp_c.last, out_last);
            n_fail++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_LENGTH) begin
        length_reg = pwdata[LEN_W-1:0];
        loaded     = 0;
      end
      if (start && !busy) begin
        m_eff = batch_len(length_reg);
        if (loaded >= m_eff) loaded = 0;
        f_re_mem[loaded] = in_f_re;
        f_im_mem[loaded] = in_f_im;
        g_re_mem[loaded] = in_g_re;
        g_im_mem[loaded] = in_g_im;
        loaded++;
        if (loaded >= m_eff) begin
          loaded = 0;
          convolve_batch(m_eff);
        end
      end
      n_pending <= h_pending_q.size();
    end
  end

endmodule

@@ tb/sv/hermitian_direct_convolution_top_tb.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict only; all prediction and comparison sits in the
// checker instance beside the block.
module hermitian_direct_convolution_top_tb;
  import hdc_pkg::*;

  // slowest legal run is roughly 400 items at length 64 with the longest
  // sender gap, plus idle waits round each register write
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 124;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [IN_W-1:0]    in_f_re = '0;
  logic signed [IN_W-1:0]    in_f_im = '0;
  logic signed [IN_W-1:0]    in_g_re = '0;
  logic signed [IN_W-1:0]    in_g_im = '0;
  logic                      out_valid;
  logic signed [OUT_W-1:0]   out_h_re;
  logic signed [OUT_W-1:0]   out_h_im;
  logic                      out_last;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [PADDR_W-1:0]        paddr = '0;
  logic [PDATA_W-1:0]        pwdata = '0;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;

  int n_fail;
  int n_pending;
  int n_checked;
  int cycle_count = 0;
  int items_sent = 0;
  int len_writes = 0;
  int idle_pct = 0;

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  hermitian_direct_convolution_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_f_re  (in_f_re),
    .in_f_im  (in_f_im),
    .in_g_re  (in_g_re),
    .in_g_im  (in_g_im),
    .out_valid(out_valid),
    .out_h_re (out_h_re),
    .out_h_im (out_h_im),
    .out_last (out_last),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  hdc_spectrum_checker chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_f_re  (in_f_re),
    .in_f_im  (in_f_im),
    .in_g_re  (in_g_re),
    .in_g_im  (in_g_im),
    .out_valid(out_valid),
    .out_h_re (out_h_re),
    .out_h_im (out_h_im),
    .out_last (out_last),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .n_fail   (n_fail),
    .n_pending(n_pending),
    .n_checked(n_checked)
  );

  // watchdog: a lost result or a stuck busy ends here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("hermitian_direct_convolution_top_tb: errors");
      $finish;
    end
  end

  // Hold start low until no H component is outstanding and busy has
  // dropped. The first edge lets the checker register any transfer made at
  // the edge we were called on; the tail adds margin once busy has fallen.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (n_pending != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One transfer: start stays high through any busy stall and is left high
  // on return, so a back-to-back item needs no second assignment.
  task automatic send_item(logic signed [IN_W-1:0] fr, logic signed [IN_W-1:0] fi,
                           logic signed [IN_W-1:0] gr, logic signed [IN_W-1:0] gi);
    in_f_re <= fr;
    in_f_im <= fi;
    in_g_re <= gr;
    in_g_im <= gi;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // Setup then access phase; pready is tied high so the write lands on the
  // access edge. Upper data bits are junk the register should ignore.
  task automatic write_length(logic [LEN_W-1:0] value);
    logic [PDATA_W-1:0] word;
    wait_idle();
    word             = $urandom();
    word[LEN_W-1:0]  = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_LENGTH, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    len_writes++;
  endtask

  // Q1.15 sample biased towards the rails and small magnitudes
  function automatic logic signed [IN_W-1:0] q15_sample(bit rails_only);
    logic [IN_W-1:0] r;
    r = IN_W'($urandom());
    if (rails_only) return r[0] ? 16'sh7FFF : 16'sh8000;
    case ($urandom_range(7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return $signed(r) >>> 11;
      default: return r;
    endcase
  endfunction

  task automatic send_random(bit rails_only);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    send_item(q15_sample(rails_only), q15_sample(rails_only),
              q15_sample(rails_only), q15_sample(rails_only));
  endtask

  initial begin
    logic [LEN_W-1:0] len;
    int               eff;
    int               n_batch;
    int               phase_items;
    int               pick;
    bit               rails;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part, no sender gaps ----
    // zero length behaves as one: every transfer completes a batch
    write_length('0);
    send_item(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_item(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_item(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
    send_item(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);

    // partial batch thrown away by a length write part way through
    write_length(7'd3);
    send_item(16'sh1234, 16'sh7FFF, 16'sh8000, 16'sh4321);
    write_length(7'd2);
    send_item(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
    send_item(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);

    // short batch at the rails exercises all three partial sums
    write_length(7'd3);
    send_item(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_item(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
    send_item(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);

    write_length(7'd1);
    send_item(16'sh0001, -16'sh0001, -16'sh0001, 16'sh0001);

    // ---- random part: three idling regimes ----
    // phase 0 opens with an out-of-range length (saturates to the store
    // depth), phase 2 with a full-depth batch of rail values
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct    = (ph == 0) ? 29 : (ph == 1) ? 55 : 0;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        rails = 1'b0;
        if (phase_items == 0 && ph != 1) begin
          len   = (ph == 0) ? 7'd127 : 7'd64;
          rails = (ph == 2);
        end else begin
          pick = $urandom_range(99);
          if (pick < 8)       len = '0;
          else if (pick < 80) len = LEN_W'($urandom_range(1, 8));
          else if (pick < 97) len = LEN_W'($urandom_range(9, 24));
          else                len = LEN_W'($urandom_range(65, 127));
        end
        // every write waits for all outstanding components first
        write_length(len);
        eff     = (len == 0) ? 1 : (int'(len) > MAX_LEN_DEF) ? MAX_LEN_DEF : int'(len);
        n_batch = (eff > 24) ? 1 : $urandom_range(1, 4);
        repeat (n_batch) begin
          repeat (eff) begin
            send_random(rails);
            phase_items++;
          end
        end
        // occasional unfinished batch, dropped by the next write
        if (eff > 1 && $urandom_range(5) == 0) begin
          repeat ($urandom_range(1, eff - 1)) begin
            send_random(1'b0);
            phase_items++;
          end
        end
      end
    end

    wait_idle();
    $display("run covered %0d input transfers and %0d length writes over three idling regimes",
             items_sent, len_writes);
    $display("%0d output components compared, %0d mismatches", n_checked, n_fail);
    if (n_fail == 0) begin
      $display("hermitian_direct_convolution_top_tb: clean");
    end else begin
      $display("hermitian_direct_convolution_top_tb: errors");
    end
    $finish;
  end

endmodule

@@ hermitian_direct_convolution_top.f @@
rtl/hdc_pkg.sv
rtl/hdc_ctrl.sv
rtl/hdc_dp.sv
rtl/hermitian_direct_convolution_top.sv
rtl/hdc_chk.sv
tb/sv/hdc_spectrum_checker.sv
tb/sv/hermitian_direct_convolution_top_tb.sv
